>>> rtl/core/tpcc_pkg.sv
// Package for the track charge correction block: widths, opcodes, register indexes.
// No dependencies.
package tpcc_pkg;

	localparam int MaxTerms  = 16;
	localparam int TermAw    = 4;
	localparam int MaxHits   = 255;
	localparam int HitCntW   = 8;
	localparam int HitSumW   = 40;
	localparam int ExpW      = 3;
	localparam int TermExpW  = 12;
	localparam int CoordW    = 16;
	localparam int ValW      = 32;
	localparam int TotalW    = 40;
	localparam int MonoW     = 17;

	typedef enum logic [1:0] {
		OP_TERM  = 2'd0,
		OP_HIT   = 2'd1,
		OP_EVENT = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam logic [0:0] REG_TERM_COUNT  = 1'd0;
	localparam logic [0:0] REG_CHARGE_MODE = 1'd1;

	localparam logic [1:0] MODE_MEAN  = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd2;

	// Stored term: coefficient and packed exponents.
	typedef struct packed {
		logic [TermExpW-1:0]   exps;
		logic signed [ValW-1:0] coef;
	} term_t;

	// floor((t + 2^14) / 2^15) is an arithmetic shift after the bias.
	function automatic logic signed [MonoW-1:0] round_mono(input logic signed [48:0] t);
		logic signed [48:0] b;
		b = t + 49'sd16384;
		return b[15+MonoW-1:15];
	endfunction

	function automatic logic signed [TotalW-1:0] round_term(input logic signed [48:0] t);
		logic signed [48:0] b;
		b = t + 49'sd16384;
		return TotalW'(b >>> 15);
	endfunction

endpackage

>>> rtl/core/tpcc_if.sv
// Valid/ready channel interfaces for input items, results and register writes.
// No dependencies.
interface tpcc_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     opcode;
	logic [3:0]                     term_index;
	logic [2:0]                     exp_x;
	logic [2:0]                     exp_y;
	logic [2:0]                     exp_a;
	logic [2:0]                     exp_b;
	logic signed [31:0]             value;
	logic signed [15:0]             pos_x;
	logic signed [15:0]             pos_y;
	logic signed [15:0]             slope_a;
	logic signed [15:0]             slope_b;
	modport source (output valid, opcode, term_index, exp_x, exp_y, exp_a, exp_b, value,
		pos_x, pos_y, slope_a, slope_b, input ready);
	modport sink (input valid, opcode, term_index, exp_x, exp_y, exp_a, exp_b, value,
		pos_x, pos_y, slope_a, slope_b, output ready);
endinterface

interface tpcc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] timing_out;
	logic signed [31:0] corrected_charge;
	logic               saturated;
	modport source (output valid, timing_out, corrected_charge, saturated, input ready);
	modport sink (input valid, timing_out, corrected_charge, saturated, output ready);
endinterface

interface tpcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tpcc_div.sv
// Restoring divider for the mean charge: signed 40-bit sum by 8-bit count.
// Depends on tpcc_pkg. One quotient bit per cycle.
module tpcc_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [tpcc_pkg::HitSumW-1:0]   dividend,
	input  logic [tpcc_pkg::HitCntW-1:0]          divisor,
	output logic                                  done,
	output logic signed [tpcc_pkg::HitSumW-1:0]   quotient
);
	localparam int W = tpcc_pkg::HitSumW;

	logic [W-1:0]                  num_q;
	logic [W-1:0]                  quo_q;
	logic [tpcc_pkg::HitCntW:0]    rem_q;
	logic [tpcc_pkg::HitCntW-1:0]  den_q;
	logic [5:0]                    cnt_q;
	logic                          neg_q;
	logic                          busy_q;
	logic [tpcc_pkg::HitCntW:0]    trial;
	logic [tpcc_pkg::HitCntW:0]    diff;

	always_comb begin
		trial = {rem_q[tpcc_pkg::HitCntW-1:0], num_q[W-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(W);
				neg_q  <= dividend[W-1];
				num_q  <= dividend[W-1] ? W'(-dividend) : W'(dividend);
				den_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= '0;
			end else if (busy_q) begin
				if (!diff[tpcc_pkg::HitCntW]) begin
					rem_q <= diff;
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				num_q <= {num_q[W-2:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

>>> rtl/core/track_polynomial_charge_correction.sv
// Top level of the track charge correction block: term memory, hit accumulation,
// term evaluation sequencer. Depends on tpcc_pkg, tpcc_if, tpcc_div.
//
//  channel  dir  contents
//  in       in   opcode, term_index, exponents, value, track coordinates
//  out      out  timing_out, corrected_charge, saturated
//  cfg      in   index (0 term_count, 1 charge_mode), data
//
// Term writes and hits keep the sequencer idle. In mean mode an event first runs the
// serial divider; then, per active term, the sequencer reads the memory, raises the
// monomial one coordinate multiply per exponent unit and adds the coefficient product,
// skipping an all-zero entry after its read; last it saturates the total. Reset clears the
// hit accumulation and term count and sets first-hit mode; term memory is undefined until
// written. New items are taken while a result waits; the next result holds until read.
module track_polynomial_charge_correction (
	input logic       clk,
	input logic       arst_n,
	tpcc_in_if.sink   in,
	tpcc_out_if.source out,
	tpcc_cfg_if.sink  cfg
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_MONO  = 7'b0001000,
		ST_COEF  = 7'b0010000,
		ST_ACC   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	tpcc_pkg::term_t term_mem [tpcc_pkg::MaxTerms];
	tpcc_pkg::term_t rd_q;

	logic [4:0]  term_count_q;
	logic [1:0]  charge_mode_q;
	logic signed [tpcc_pkg::HitSumW-1:0] hit_sum_q;
	logic [tpcc_pkg::HitCntW-1:0]        hit_count_q;
	logic signed [31:0]                  first_hit_q;

	logic signed [31:0] timing_q;
	logic signed [15:0] coord_q [4];
	logic [4:0]  idx_q;
	logic [4:0]  n_terms;
	logic [1:0]  dim_q;
	logic [3:0]  left_q;
	logic signed [tpcc_pkg::MonoW-1:0]  mono_q;
	logic signed [48:0]                 prod_q;
	logic signed [tpcc_pkg::TotalW-1:0] total_q;
	logic        out_valid_q;
	logic signed [31:0] out_charge_q;
	logic signed [31:0] out_timing_q;
	logic        out_sat_q;

	logic        div_start;
	logic        div_done;
	logic signed [tpcc_pkg::HitSumW-1:0] div_quo;

	logic        acc_in;
	logic        done_load;
	logic [2:0]  exp_sel;
	logic [2:0]  exp_of [4];

	assign acc_in  = in.valid && in.ready;
	assign n_terms = (term_count_q > 5'(tpcc_pkg::MaxTerms)) ? 5'(tpcc_pkg::MaxTerms)
		: term_count_q;
	// Next item waits while an event evaluates or its result waits to enter the output register.
	assign in.ready  = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	// Load the output register once the previous result is gone or leaves now.
	assign done_load = (state_q == ST_DONE) && (!out_valid_q || out.ready);

	always_comb begin
		for (int j = 0; j < 4; j++) exp_of[j] = rd_q.exps[3*j +: 3];
		exp_sel = exp_of[dim_q];
	end

	assign div_start = acc_in && (tpcc_pkg::opcode_t'(in.opcode) == tpcc_pkg::OP_EVENT)
		&& (hit_count_q != '0) && (charge_mode_q == tpcc_pkg::MODE_MEAN);

	tpcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (hit_sum_q),
		.divisor  (hit_count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Term memory write and registered read.
	always_ff @(posedge clk) begin
		if (acc_in && (tpcc_pkg::opcode_t'(in.opcode) == tpcc_pkg::OP_TERM))
			term_mem[in.term_index] <= '{exps: {in.exp_b, in.exp_a, in.exp_y, in.exp_x},
				coef: in.value};
		rd_q <= term_mem[idx_q[tpcc_pkg::TermAw-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			term_count_q  <= '0;
			charge_mode_q <= 2'd2;
			hit_sum_q     <= '0;
			hit_count_q   <= '0;
			first_hit_q   <= '0;
			out_valid_q   <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == tpcc_pkg::REG_TERM_COUNT) term_count_q <= cfg.data[4:0];
				else charge_mode_q <= cfg.data[1:0];
			end
			if (done_load) out_valid_q <= 1'b1;
			else if (out.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						case (tpcc_pkg::opcode_t'(in.opcode))
							tpcc_pkg::OP_HIT: begin
								if (hit_count_q < 8'(tpcc_pkg::MaxHits)) begin
									if (hit_count_q == '0) first_hit_q <= in.value;
									hit_sum_q   <= hit_sum_q + 40'(in.value);
									hit_count_q <= hit_count_q + 8'd1;
								end
							end
							tpcc_pkg::OP_EVENT: begin
								if (hit_count_q != '0) begin
									timing_q   <= in.value;
									coord_q[0] <= in.pos_x;
									coord_q[1] <= in.pos_y;
									coord_q[2] <= in.slope_a;
									coord_q[3] <= in.slope_b;
									idx_q      <= '0;
									if (charge_mode_q == tpcc_pkg::MODE_FIRST)
										total_q <= 40'(first_hit_q);
									else
										total_q <= '0;
									state_q <= (charge_mode_q == tpcc_pkg::MODE_MEAN) ? ST_DIV
										: ST_READ;
								end
								hit_sum_q   <= '0;
								hit_count_q <= '0;
								first_hit_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						total_q <= div_quo;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					// Address is presented; data lands in rd_q next cycle.
					if (idx_q >= n_terms) state_q <= ST_DONE;
					else begin
						state_q <= ST_MONO;
						mono_q  <= 17'sd32768;
						dim_q   <= '0;
						left_q  <= 4'd8;
					end
				end
				ST_MONO: begin
					// left_q of eight means the exponent of this coordinate is not loaded yet.
					if (rd_q.exps == '0) begin
						idx_q   <= idx_q + 5'd1;
						state_q <= ST_READ;
					end else if (left_q == 4'd8) begin
						left_q <= {1'b0, exp_sel};
					end else if (left_q != '0) begin
						mono_q <= tpcc_pkg::round_mono(49'(mono_q * coord_q[dim_q]));
						left_q <= left_q - 4'd1;
					end else if (dim_q == 2'd3) begin
						state_q <= ST_COEF;
					end else begin
						dim_q  <= dim_q + 2'd1;
						left_q <= 4'd8;
					end
				end
				ST_COEF: begin
					prod_q  <= 49'(rd_q.coef * mono_q);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					total_q <= total_q + tpcc_pkg::round_term(prod_q);
					idx_q   <= idx_q + 5'd1;
					state_q <= ST_READ;
				end
				ST_DONE: begin
					if (done_load) begin
						out_timing_q <= timing_q;
						out_sat_q    <= (total_q > 40'sd2147483647)
							|| (total_q < -40'sd2147483648);
						if (total_q > 40'sd2147483647) out_charge_q <= 32'sh7fffffff;
						else if (total_q < -40'sd2147483648) out_charge_q <= 32'sh80000000;
						else out_charge_q <= total_q[31:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out.valid            = out_valid_q;
	assign out.timing_out       = out_timing_q;
	assign out.corrected_charge = out_charge_q;
	assign out.saturated        = out_sat_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_ovr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out.ready) |=> (out_valid_q && $stable(out_charge_q)
		&& $stable(out_timing_q))) else $error("result overwritten");
	a_hits_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_DONE) |-> (hit_count_q == '0))
		else $error("hits not cleared");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hit_count_q <= 8'(tpcc_pkg::MaxHits)) else $error("hit count overflow");
endmodule

>>> bench/track_polynomial_charge_correction_test.sv
// Testbench for track_polynomial_charge_correction: directed cases, then random
// term writes, hits and events checked against an in-bench predictor of the correction.
// Depends on tpcc_pkg and tpcc_if.
`timescale 1ns / 1ps

module track_polynomial_charge_correction_test;

	typedef struct {
		tpcc_pkg::opcode_t op;
		logic [3:0]       idx;
		logic [2:0]       ex, ey, ea, eb;
		logic signed [31:0] val;
		logic signed [15:0] px, py, sa, sb;
	} request_t;

	typedef struct {
		logic signed [31:0] timing;
		logic signed [31:0] charge;
		logic               sat;
	} corrected_t;

	typedef struct {
		request_t req;
		logic     typed;   // use the typed-in charge instead of the predictor
		logic signed [31:0] charge;
		logic     sat;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;

	tpcc_in_if  in_ch();
	tpcc_out_if out_ch();
	tpcc_cfg_if cfg_ch();

	track_polynomial_charge_correction dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#50ms;
		$display("Timeout");
		$display("*** FAILED ***");
		$finish;
	end

	// predictor state
	logic [11:0]        pred_exps [tpcc_pkg::MaxTerms];
	logic signed [31:0] pred_coefs [tpcc_pkg::MaxTerms];
	logic signed [63:0] pred_sum;
	int unsigned        pred_count;
	logic signed [31:0] pred_first;
	int unsigned        pred_terms;
	logic [1:0]         pred_mode;

	corrected_t charge_queue[$];
	int mismatches = 0;
	int results_seen = 0;
	int events_sent = 0;

	function automatic logic signed [63:0] rnd15(logic signed [63:0] t);
		return (t + 64'sd16384) >>> 15;
	endfunction

	function automatic bit correct_charge(request_t r, output corrected_t c);
		logic signed [63:0] total, mono, base;
		logic signed [63:0] crd [4];
		int n;
		if (pred_count == 0)
			return 0;
		base = 0;
		if (pred_mode == tpcc_pkg::MODE_FIRST)
			base = pred_first;
		else if (pred_mode == tpcc_pkg::MODE_MEAN)
			base = pred_sum / $signed({32'd0, pred_count});
		crd[0] = r.px; crd[1] = r.py; crd[2] = r.sa; crd[3] = r.sb;
		n = pred_terms < tpcc_pkg::MaxTerms ? pred_terms : tpcc_pkg::MaxTerms;
		total = base;
		for (int i = 0; i < n; i++) begin
			if (pred_exps[i] == 0)
				continue;
			mono = 32768;
			for (int j = 0; j < 4; j++)
				for (int k = 0; k < pred_exps[i][3*j +: 3]; k++)
					mono = rnd15(mono * crd[j]);
			total += rnd15(64'(pred_coefs[i]) * mono);
		end
		c.timing = r.val;
		c.sat = 0;
		if (total > 64'sd2147483647) begin
			total = 64'sd2147483647; c.sat = 1;
		end else if (total < -64'sd2147483648) begin
			total = -64'sd2147483648; c.sat = 1;
		end
		c.charge = total[31:0];
		pred_sum = 0; pred_count = 0; pred_first = 0;
		return 1;
	endfunction

	// update the predictor; returns 1 with an expected result for events that find hits
	function automatic bit apply_request(request_t r, output corrected_t c);
		c = '{default: 0};
		case (r.op)
			tpcc_pkg::OP_TERM: begin
				pred_exps[r.idx] = {r.eb, r.ea, r.ey, r.ex};
				pred_coefs[r.idx] = r.val;
			end
			tpcc_pkg::OP_HIT: if (pred_count < tpcc_pkg::MaxHits) begin
				if (pred_count == 0)
					pred_first = r.val;
				pred_sum += r.val;
				pred_count++;
			end
			tpcc_pkg::OP_EVENT: return correct_charge(r, c);
			default: ;
		endcase
		return 0;
	endfunction

	// drive one request with a random gap; valid stays high when the gap is zero
	task automatic send_request(request_t r);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap != 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.opcode <= r.op; in_ch.term_index <= r.idx;
		in_ch.exp_x <= r.ex; in_ch.exp_y <= r.ey; in_ch.exp_a <= r.ea; in_ch.exp_b <= r.eb;
		in_ch.value <= r.val;
		in_ch.pos_x <= r.px; in_ch.pos_y <= r.py; in_ch.slope_a <= r.sa; in_ch.slope_b <= r.sb;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic issue(request_t r, bit typed = 0, logic signed [31:0] chg = 0,
			logic sat = 0);
		corrected_t c;
		if (apply_request(r, c)) begin
			if (typed) begin
				c.charge = chg; c.sat = sat;
			end
			charge_queue.insert(charge_queue.size(), c);
			events_sent++;
		end
		send_request(r);
	endtask

	task automatic drain_and_settle();
		in_ch.valid <= 0;
		while (charge_queue.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(logic [0:0] index, logic [31:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1; cfg_ch.index <= index; cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 0;
		if (index == tpcc_pkg::REG_TERM_COUNT)
			pred_terms = 32'(data[4:0]);
		else
			pred_mode = data[1:0];
	endtask

	function automatic request_t blank(tpcc_pkg::opcode_t op, logic signed [31:0] v);
		request_t r;
		r = '{op: op, idx: 0, ex: 0, ey: 0, ea: 0, eb: 0, val: v,
			px: 0, py: 0, sa: 0, sb: 0};
		return r;
	endfunction

	function automatic request_t random_request(int unsigned live);
		request_t r;
		int unsigned k;
		r = blank(tpcc_pkg::OP_HIT, $urandom);
		r.idx = 4'($urandom_range(0, 15));
		{r.ex, r.ey, r.ea, r.eb} = 12'($urandom);
		r.px = 16'($urandom); r.py = 16'($urandom);
		r.sa = 16'($urandom); r.sb = 16'($urandom);
		if ($urandom_range(0, 3) == 0)
			r.val = $signed($urandom_range(0, 2000000)) - 1000000;
		k = $urandom_range(0, 99);
		if (k < 10) begin
			r.op = tpcc_pkg::OP_TERM;
			// keep writes inside the live range so every read entry stays defined
			if (live > 0)
				r.idx = 4'($urandom_range(0, live - 1));
		end else if (k < 65)
			r.op = tpcc_pkg::OP_HIT;
		else if (k < 97)
			r.op = tpcc_pkg::OP_EVENT;
		else
			r.op = tpcc_pkg::OP_NONE;
		return r;
	endfunction

	// result checker: before each result, ready is held low for a random gap (possibly none)
	initial begin
		corrected_t e;
		int stall;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 6);
			if (stall != 0) begin
				out_ch.ready <= 0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!out_ch.valid);
			results_seen++;
			if (charge_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result timing=%0d", out_ch.timing_out);
			end else begin
				e = charge_queue.pop_front();
				if (out_ch.timing_out !== e.timing || out_ch.corrected_charge !== e.charge
						|| out_ch.saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: exp %0d %0d %0b got %0d %0d %0b",
							e.timing, e.charge, e.sat, out_ch.timing_out,
							out_ch.corrected_charge, out_ch.saturated);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		table_row_t rows[$];
		request_t r;
		int unsigned live;
		in_ch.valid = 0; in_ch.opcode = tpcc_pkg::OP_NONE; in_ch.term_index = 0;
		in_ch.exp_x = 0; in_ch.exp_y = 0; in_ch.exp_a = 0; in_ch.exp_b = 0;
		in_ch.value = 0; in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.slope_a = 0;
		in_ch.slope_b = 0;
		cfg_ch.valid = 0; cfg_ch.index = tpcc_pkg::REG_TERM_COUNT; cfg_ch.data = 0;
		pred_sum = 0; pred_count = 0; pred_first = 0; pred_terms = 0;
		pred_mode = tpcc_pkg::MODE_FIRST;
		foreach (pred_exps[i]) begin
			pred_exps[i] = 0; pred_coefs[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// after reset: first-hit mode, no terms
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_EVENT, 32'sd7), 0, 0, 0}); // no result
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_HIT, 32'sd2147483647), 0, 0, 0});
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_HIT, -32'sd5), 0, 0, 0});
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_EVENT, -32'sd2147483648), 1,
			32'sd2147483647, 0});
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_NONE, 32'sd1), 0, 0, 0});
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_HIT, -32'sd2147483648), 0, 0, 0});
		rows.insert(rows.size(), '{blank(tpcc_pkg::OP_EVENT, 32'sd3), 1,
			-32'sd2147483648, 0});
		foreach (rows[i]) issue(rows[i].req, rows[i].typed, rows[i].charge, rows[i].sat);
		rows.delete();
		drain_and_settle();

		// load all 16 terms with extreme and zero exponents, then evaluate
		for (int i = 0; i < tpcc_pkg::MaxTerms; i++) begin
			r = blank(tpcc_pkg::OP_TERM, (i % 2) ? 32'sd2147483647 : -32'sd2147483648);
			r.idx = 4'(i);
			if (i != 3)
				{r.ex, r.ey, r.ea, r.eb} = (i == 0) ? 12'hfff : 12'(i * 291);
			issue(r);
		end
		drain_and_settle();
		write_register(tpcc_pkg::REG_TERM_COUNT, 32'd31);
		write_register(tpcc_pkg::REG_CHARGE_MODE, {30'd0, tpcc_pkg::MODE_MEAN});
		r = blank(tpcc_pkg::OP_HIT, 32'sd2147483647); issue(r); issue(r);
		r = blank(tpcc_pkg::OP_EVENT, 32'sd9);
		r.px = -16'sd32768; r.py = -16'sd32768; r.sa = 16'sd32767; r.sb = -16'sd32768;
		issue(r);
		r = blank(tpcc_pkg::OP_HIT, -32'sd3); issue(r);
		r = blank(tpcc_pkg::OP_EVENT, 32'sd4); r.px = 16'sd32767; r.py = 16'sd32767;
		r.sa = 16'sd32767; r.sb = 16'sd32767; issue(r);
		drain_and_settle();
		// send more hits than the capped hit counter takes
		for (int i = 0; i < 260; i++) issue(blank(tpcc_pkg::OP_HIT, 32'sd65536 * (i % 7)));
		issue(blank(tpcc_pkg::OP_EVENT, 32'sd11));
		drain_and_settle();

		// random phases over register settings
		live = 16;
		for (int ph = 0; ph < 6; ph++) begin
			write_register(tpcc_pkg::REG_TERM_COUNT, (ph == 1) ? 32'd0 : (ph == 2) ? 32'd1 :
				$urandom_range(0, 31));
			write_register(tpcc_pkg::REG_CHARGE_MODE, ph % 4);
			for (int n = 0; n < 210; n++) issue(random_request(live));
			drain_and_settle();
		end

		$display("Sent %0d events, checked %0d results over six register settings.",
			events_sent, results_seen);
		if (mismatches == 0 && charge_queue.size() == 0)
			$display("*** PASSED ***");
		else begin
			$display("%0d mismatches, %0d results missing", mismatches, charge_queue.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
